/* rtl/core/cpc_pkg.sv */
// Shared types and constants for the coprime pair counter.
// Used by cpc_ctrl, cpc_datapath and coprime_pair_counter_core.
`default_nettype none

package cpc_pkg;

    // Width of each count field on the result bus
    localparam int FIELD_BITS = 32;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_STRIP_A,
        ST_STRIP_B,
        ST_SUB,
        ST_COMMIT
    } state_t;

    typedef struct packed {
        logic load;
        logic shift_a;
        logic shift_b;
        logic sub_step;
        logic commit;
        logic verdict;
    } cmd_t;

    typedef struct packed {
        logic both_even;
        logic a_even;
        logic a_one;
        logic b_even;
        logic b_one;
        logic diff_zero;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

/* rtl/core/coprime_pair_counter_core.sv */
// Top level of the coprime pair counter: stream ports, sequencer and datapath.
// Depends on cpc_pkg, cpc_ctrl and cpc_datapath.
//
//  port group  dir  tdata (low bit up)                       tuser
//  s_*         in   first_raw, second_raw, zero pad to bytes  restart
//  m_*         out  coprime_total[31:0], trial_total[31:0]    is_coprime
//
// From acceptance to result a pair steps through load, parity check, the
// halving steps and the odd check that ends each strip, and the subtract
// steps of the binary GCD loop, then commit.
// The result sits in an output register, so the next pair is taken while it
// waits; a stalled result only holds the commit step of the pair after it.
// rst_n clears the counts, the sequencer and the output valid.
`default_nettype none

module coprime_pair_counter_core #(
    parameter int VALUE_BITS = 12,
    parameter int COUNT_BITS = 32
) (
    input  wire                                   clk,
    input  wire                                   rst_n,
    input  wire                                   s_tvalid,
    output logic                                  s_tready,
    // first_raw, second_raw, zero padding
    input  wire  [((2*VALUE_BITS+7)/8)*8-1:0]     s_tdata,
    // restart
    input  wire                                   s_tuser,
    output logic                                  m_tvalid,
    input  wire                                   m_tready,
    // coprime_total, trial_total
    output logic [2*cpc_pkg::FIELD_BITS-1:0]      m_tdata,
    // is_coprime
    output logic                                  m_tuser
);
    import cpc_pkg::*;

    cmd_t                  cmd;
    status_t               status;
    logic [FIELD_BITS-1:0] coprime_total;
    logic [FIELD_BITS-1:0] trial_total;

    cpc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    cpc_datapath #(
        .VALUE_BITS (VALUE_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .first_raw         (s_tdata[VALUE_BITS-1:0]),
        .second_raw        (s_tdata[2*VALUE_BITS-1:VALUE_BITS]),
        .restart           (s_tuser),
        .cmd               (cmd),
        .status            (status),
        .out_valid         (m_tvalid),
        .out_ready         (m_tready),
        .out_coprime       (m_tuser),
        .out_coprime_total (coprime_total),
        .out_trial_total   (trial_total)
    );

    assign m_tdata = {trial_total, coprime_total};

endmodule

`default_nettype wire

/* rtl/core/cpc_ctrl.sv */
// Sequencer for the binary GCD test: walks strip, subtract and commit steps.
// Depends on cpc_pkg; drives cpc_datapath through cmd_t and reads status_t.
`default_nettype none

module cpc_ctrl (
    input  wire              clk,
    input  wire              rst_n,
    input  wire              in_valid,
    output logic             in_ready,
    input  cpc_pkg::status_t status,
    output cpc_pkg::cmd_t    cmd
);
    import cpc_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   verdict_reg;
    logic   verdict_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            verdict_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            verdict_reg <= verdict_next;
        end
    end

    // next state
    always_comb
    begin
        state_next   = state_reg;
        verdict_next = verdict_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (status.both_even)
                begin
                    verdict_next = 1'b0;
                    state_next   = ST_COMMIT;
                end
                else
                begin
                    state_next = ST_STRIP_A;
                end
            end
            ST_STRIP_A:
            begin
                if (!status.a_even)
                begin
                    if (status.a_one)
                    begin
                        verdict_next = 1'b1;
                        state_next   = ST_COMMIT;
                    end
                    else
                    begin
                        state_next = ST_STRIP_B;
                    end
                end
            end
            ST_STRIP_B:
            begin
                if (!status.b_even)
                begin
                    if (status.b_one)
                    begin
                        verdict_next = 1'b1;
                        state_next   = ST_COMMIT;
                    end
                    else
                    begin
                        state_next = ST_SUB;
                    end
                end
            end
            ST_SUB:
            begin
                // equal odd values above one: common factor found
                if (status.diff_zero)
                begin
                    verdict_next = 1'b0;
                    state_next   = ST_COMMIT;
                end
                else
                begin
                    state_next = ST_STRIP_B;
                end
            end
            ST_COMMIT:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready     = 1'b0;
        cmd          = '0;
        cmd.verdict  = verdict_reg;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_STRIP_A:
            begin
                cmd.shift_a = status.a_even;
            end
            ST_STRIP_B:
            begin
                cmd.shift_b = status.b_even;
            end
            ST_SUB:
            begin
                cmd.sub_step = 1'b1;
            end
            ST_COMMIT:
            begin
                cmd.commit = status.out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

/* rtl/core/cpc_datapath.sv */
// Operand registers, subtractor, saturating counts and result register.
// Depends on cpc_pkg; commanded by cpc_ctrl.
`default_nettype none

module cpc_datapath #(
    parameter int VALUE_BITS = 12,
    parameter int COUNT_BITS = 32
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire  [VALUE_BITS-1:0]            first_raw,
    input  wire  [VALUE_BITS-1:0]            second_raw,
    input  wire                              restart,
    input  cpc_pkg::cmd_t                    cmd,
    output cpc_pkg::status_t                 status,
    output logic                             out_valid,
    input  wire                              out_ready,
    output logic                             out_coprime,
    output logic [cpc_pkg::FIELD_BITS-1:0]   out_coprime_total,
    output logic [cpc_pkg::FIELD_BITS-1:0]   out_trial_total
);
    import cpc_pkg::*;

    localparam int OP_BITS   = VALUE_BITS + 1;
    localparam int WIDE_BITS = COUNT_BITS + FIELD_BITS;

    logic [OP_BITS-1:0]    a_reg;
    logic [OP_BITS-1:0]    b_reg;
    logic                  restart_reg;
    logic [COUNT_BITS-1:0] coprime_count_reg;
    logic [COUNT_BITS-1:0] trial_count_reg;
    logic                  out_valid_reg;
    logic                  out_coprime_reg;
    logic [FIELD_BITS-1:0] out_coprime_total_reg;
    logic [FIELD_BITS-1:0] out_trial_total_reg;

    logic                  a_gt_b;
    logic [OP_BITS-1:0]    diff;
    logic [OP_BITS-1:0]    min_val;
    logic [COUNT_BITS-1:0] coprime_base;
    logic [COUNT_BITS-1:0] trial_base;
    logic [COUNT_BITS-1:0] coprime_count_next;
    logic [COUNT_BITS-1:0] trial_count_next;
    logic [WIDE_BITS-1:0]  coprime_wide;
    logic [WIDE_BITS-1:0]  trial_wide;

    assign a_gt_b  = a_reg > b_reg;
    assign diff    = a_gt_b ? (a_reg - b_reg) : (b_reg - a_reg);
    assign min_val = a_gt_b ? b_reg : a_reg;

    assign status.both_even = !a_reg[0] && !b_reg[0];
    assign status.a_even    = !a_reg[0];
    assign status.a_one     = a_reg == OP_BITS'(1);
    assign status.b_even    = !b_reg[0];
    assign status.b_one     = b_reg == OP_BITS'(1);
    assign status.diff_zero = diff == '0;
    assign status.out_free  = !out_valid_reg || out_ready;

    // restart clears the counts before this pair is counted
    assign coprime_base = restart_reg ? '0 : coprime_count_reg;
    assign trial_base   = restart_reg ? '0 : trial_count_reg;

    always_comb
    begin
        trial_count_next   = (trial_base == '1) ? trial_base : trial_base + 1'b1;
        coprime_count_next = coprime_base;
        if (cmd.verdict && (coprime_base != '1))
        begin
            coprime_count_next = coprime_base + 1'b1;
        end
    end

    assign coprime_wide = WIDE_BITS'(coprime_count_next);
    assign trial_wide   = WIDE_BITS'(trial_count_next);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            a_reg       <= OP_BITS'(first_raw) + OP_BITS'(1);
            b_reg       <= OP_BITS'(second_raw) + OP_BITS'(1);
            restart_reg <= restart;
        end
        else
        begin
            if (cmd.shift_a)
            begin
                a_reg <= a_reg >> 1;
            end
            if (cmd.shift_b)
            begin
                b_reg <= b_reg >> 1;
            end
            else if (cmd.sub_step)
            begin
                a_reg <= min_val;
                b_reg <= diff;
            end
        end
        if (cmd.commit)
        begin
            out_coprime_reg       <= cmd.verdict;
            out_coprime_total_reg <= coprime_wide[FIELD_BITS-1:0];
            out_trial_total_reg   <= trial_wide[FIELD_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coprime_count_reg <= '0;
            trial_count_reg   <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cmd.commit)
            begin
                coprime_count_reg <= coprime_count_next;
                trial_count_reg   <= trial_count_next;
                out_valid_reg     <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid         = out_valid_reg;
    assign out_coprime       = out_coprime_reg;
    assign out_coprime_total = out_coprime_total_reg;
    assign out_trial_total   = out_trial_total_reg;

endmodule

`default_nettype wire

/* test/coprime_pair_checker.sv */
// Scoreboard for coprime_pair_counter_core: predicts each result from the accepted requests
// and compares it with what leaves the master port. Depends on cpc_pkg.
module coprime_pair_checker #(
    parameter int VALUE_BITS = 12,
    parameter int COUNT_BITS = 32
) (
    input  wire                                   clk,
    input  wire                                   rst_n,
    input  wire                                   s_tvalid,
    input  wire                                   s_tready,
    // first_raw, second_raw, zero padding
    input  wire  [((2*VALUE_BITS+7)/8)*8-1:0]     s_tdata,
    // restart
    input  wire                                   s_tuser,
    input  wire                                   m_tvalid,
    input  wire                                   m_tready,
    // coprime_total, trial_total
    input  wire  [2*cpc_pkg::FIELD_BITS-1:0]      m_tdata,
    // is_coprime
    input  wire                                   m_tuser,
    output int                                    errors,
    output int                                    pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FB = cpc_pkg::FIELD_BITS;

    typedef logic [VALUE_BITS:0]   operand_t;
    typedef logic [COUNT_BITS-1:0] count_t;

    typedef struct {
        logic          coprime;
        logic [FB-1:0] coprime_total;
        logic [FB-1:0] trial_total;
    } tally_t;

    tally_t  tally_q[$];
    count_t  trials_seen;
    count_t  coprimes_seen;

    // Stein's binary gcd, reduced to a yes/no on gcd == 1
    function automatic logic stein_coprime(operand_t x, operand_t y);
        operand_t t;
        if (!x[0] && !y[0])
            return 1'b0;
        while (!x[0])
            x = x >> 1;
        if (x == 1)
            return 1'b1;
        do
        begin
            while (!y[0])
                y = y >> 1;
            if (y == 1)
                return 1'b1;
            if (x > y)
            begin
                t = x;
                x = y;
                y = t;
            end
            y = y - x;
        end while (y != 0);
        return 1'b0;
    endfunction

    function automatic count_t bump(count_t v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        operand_t x;
        operand_t y;
        tally_t   want;
        logic     co;
        if (!rst_n)
        begin
            tally_q.delete();
            trials_seen   <= '0;
            coprimes_seen <= '0;
            errors        <= 0;
            pending       <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (tally_q.size() == 0)
                begin
                    $display("%0t: result with no request pending: coprime=%0b totals=%0d/%0d",
                             $time, m_tuser, m_tdata[FB-1:0], m_tdata[2*FB-1:FB]);
                    errors <= errors + 1;
                end
                else
                begin
                    want = tally_q.pop_front();
                    if (m_tuser !== want.coprime ||
                        m_tdata[FB-1:0] !== want.coprime_total ||
                        m_tdata[2*FB-1:FB] !== want.trial_total)
                    begin
                        $display("%0t: mismatch expected coprime=%0b coprime_total=%0d trial_total=%0d",
                                 $time, want.coprime, want.coprime_total, want.trial_total);
                        $display("%0t:          actual   coprime=%0b coprime_total=%0d trial_total=%0d",
                                 $time, m_tuser, m_tdata[FB-1:0], m_tdata[2*FB-1:FB]);
                        errors <= errors + 1;
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                x  = {1'b0, s_tdata[VALUE_BITS-1:0]} + 1'b1;
                y  = {1'b0, s_tdata[2*VALUE_BITS-1:VALUE_BITS]} + 1'b1;
                co = stein_coprime(x, y);
                // restart clears first, then this pair counts
                want.coprime       = co;
                want.trial_total   = FB'(bump(s_tuser ? count_t'(0) : trials_seen));
                want.coprime_total = FB'(co ? bump(s_tuser ? count_t'(0) : coprimes_seen)
                                            : (s_tuser ? count_t'(0) : coprimes_seen));
                trials_seen   <= bump(s_tuser ? count_t'(0) : trials_seen);
                coprimes_seen <= co ? bump(s_tuser ? count_t'(0) : coprimes_seen)
                                    : (s_tuser ? count_t'(0) : coprimes_seen);
                tally_q.push_back(want);
            end
            pending <= tally_q.size();
        end
    end

endmodule

/* test/tb_coprime_pair_counter_core.sv */
// Testbench top for coprime_pair_counter_core: clock, reset, request stimulus and verdict.
// Depends on cpc_pkg, the core RTL and coprime_pair_checker.
module tb_coprime_pair_counter_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int VB = 12;
    localparam int CB = 32;
    localparam int DW = ((2*VB+7)/8)*8;
    localparam int RANDOM_PAIRS = 600;
    localparam int DRAIN_CYCLES = 3*VB + 4 + 20;

    logic                            clk = 1'b0;
    logic                            rst_n;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [DW-1:0]                   s_tdata;
    logic                            s_tuser;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [2*cpc_pkg::FIELD_BITS-1:0] m_tdata;
    logic                            m_tuser;
    logic                            calm;
    int                              errors;
    int                              pending;

    always #2 clk = ~clk;

    coprime_pair_counter_core #(.VALUE_BITS(VB), .COUNT_BITS(CB)) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    coprime_pair_checker #(.VALUE_BITS(VB), .COUNT_BITS(CB)) i_checker (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .errors   (errors),
        .pending  (pending)
    );

    // result side back-pressure
    always @(posedge clk)
        m_tready <= calm ? 1'b1 : ($urandom_range(99) >= 32);

    task automatic send_pair(logic [VB-1:0] first, logic [VB-1:0] second, logic restart);
        while (!calm && $urandom_range(99) < 32)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= DW'($urandom);
            s_tuser  <= 1'($urandom_range(1));
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= DW'({second, first});
        s_tuser  <= restart;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // values that are likely to share a factor once incremented
    function automatic logic [VB-1:0] multiple_less_one(int g);
        return VB'(g * $urandom_range((1 << VB) / g, 1) - 1);
    endfunction

    initial
    begin
        logic [VB-1:0] a;
        logic [VB-1:0] b;
        int            g;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= 1'b0;
        calm     <= 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, early exits, subtract loop, restart
        send_pair(12'd0,    12'd0,    1'b0);  // 1,1
        send_pair(12'hFFF,  12'hFFF,  1'b0);  // both even at full width
        send_pair(12'hFFF,  12'd0,    1'b0);  // 4096 strips to 1
        send_pair(12'd0,    12'hFFF,  1'b1);
        send_pair(12'd1,    12'd1,    1'b0);  // 2,2 both even
        send_pair(12'd1,    12'd2,    1'b0);  // first strips to 1
        send_pair(12'd2,    12'd1,    1'b0);  // second strips to 1
        send_pair(12'd2,    12'd4,    1'b0);  // 3,5 via subtraction
        send_pair(12'd2,    12'd8,    1'b0);  // 3,9 difference hits zero
        send_pair(12'd14,   12'd20,   1'b0);  // 15,21
        send_pair(12'hFFE,  12'hFFE,  1'b0);  // equal odd values
        send_pair(12'hFFE,  12'hFFC,  1'b1);
        send_pair(12'd2047, 12'd2047, 1'b0);
        send_pair(12'd2047, 12'd2046, 1'b0);
        send_pair(12'hAAA,  12'h555,  1'b0);
        send_pair(12'h555,  12'hAAA,  1'b0);
        send_pair(12'd3,    12'd2,    1'b1);
        send_pair(12'd4094, 12'd2,    1'b0);  // 4095,3
        send_pair(12'd2186, 12'd728,  1'b0);  // 2187,729 powers of three
        send_pair(12'd3071, 12'd4092, 1'b0);  // 3072,4093 long subtract chain

        for (int i = 0; i < RANDOM_PAIRS; i++)
        begin
            calm <= (i >= 250 && i < 350);
            case ($urandom_range(3))
                0:
                begin
                    a = VB'($urandom);
                    b = VB'($urandom);
                end
                1:
                begin
                    a = VB'($urandom_range(31));
                    b = VB'($urandom_range(31));
                end
                2:
                begin
                    g = $urandom_range(63, 2);
                    a = multiple_less_one(g);
                    b = multiple_less_one(g);
                end
                default:
                begin
                    a = VB'($urandom);
                    b = $urandom_range(1) ? a : VB'((1 << $urandom_range(VB)) - 1);
                end
            endcase
            send_pair(a, b, $urandom_range(99) < 5);
        end
        s_tvalid <= 1'b0;
        calm     <= 1'b0;

        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #2ms;
        $display("Some tests failed");
        $finish;
    end

endmodule
